[rtl/dns_response_a_record_parser_assert.svh]
// Assertion macros for the DNS response A-record parser.
// Used by the top level; the clock clk and reset arst_n must be in scope.
`ifndef DNS_RESPONSE_A_RECORD_PARSER_ASSERT_SVH
`define DNS_RESPONSE_A_RECORD_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DNSAP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DNSAP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/dnsap_pkg.sv]
// Package for the DNS response A-record parser: phase codes, status codes,
// the result record and header and record layout constants. No dependencies.
`timescale 1ns / 1ps

package dnsap_pkg;

	localparam int OFFSET_BITS_DEF = 16;

	localparam int HDR_LEN     = 12;
	localparam int HDR_IDX_W   = $clog2(HDR_LEN);
	localparam int FIELD_LEN   = 10;
	localparam int FIELD_IDX_W = $clog2(FIELD_LEN + 1);
	localparam int RDATA_LEN   = 4;

	localparam logic [15:0] ID_RESET   = 16'h1234;
	localparam logic [15:0] RCODE_MASK = 16'h000F;
	localparam logic [15:0] QR_MASK    = 16'h8000;
	localparam logic [7:0]  PTR_MASK   = 8'hC0;
	localparam logic [15:0] TYPE_A     = 16'd1;

	localparam logic [2:0] ST_SHORT     = 3'd0;
	localparam logic [2:0] ST_WRONG_ID  = 3'd1;
	localparam logic [2:0] ST_SRV_ERROR = 3'd2;
	localparam logic [2:0] ST_NOT_RESP  = 3'd3;
	localparam logic [2:0] ST_NO_ANSWER = 3'd4;
	localparam logic [2:0] ST_MALFORMED = 3'd5;
	localparam logic [2:0] ST_FOUND     = 3'd6;
	localparam logic [2:0] ST_NONE      = 3'd7;

	// Header check passed.
	localparam logic [2:0] VERDICT_OK = 3'd0;

	typedef enum logic [10:0] {
		PH_HEADER   = 11'b000_0000_0001,
		PH_Q_LABEL  = 11'b000_0000_0010,
		PH_Q_AFTER  = 11'b000_0000_0100,
		PH_A_ENTRY  = 11'b000_0000_1000,
		PH_A_START  = 11'b000_0001_0000,
		PH_A_LABEL  = 11'b000_0010_0000,
		PH_A_AFTER  = 11'b000_0100_0000,
		PH_A_FIELDS = 11'b000_1000_0000,
		PH_A_RDATA  = 11'b001_0000_0000,
		PH_DONE     = 11'b010_0000_0000,
		PH_HDR_FAIL = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] address;
		logic [3:0]  response_code;
		logic        wait_cleared;
	} result_t;

endpackage

[rtl/dns_response_a_record_parser.sv]
// Top level of the DNS response A-record parser: expected-ID register,
// byte parser and result queue. Depends on dnsap_pkg, dnsap_parse, dnsap_outq and the assertion header.
//
// Usage: the packet enters on the input channel one payload byte per
// transfer (data_byte), with last_byte set on the final byte. Each packet
// gives exactly one result on the output channel: status, address,
// response_code and wait_cleared. Bytes other than the final one give none.
// The expected transaction ID is written through cfg_wr_en / cfg_wr_data
// while the block is idle; it is compared when the twelfth byte arrives.
//
// Throughput is one byte per cycle while in_ready is high: each byte only
// updates counters and compares, in combinational parser logic. The result
// is pushed into the queue, and out_valid is high the cycle after the final byte's transfer.
// A two-entry result queue sits between the parser and the output, so bytes
// keep flowing while a result waits; in_ready drops only while both queue
// entries are held by a stalled receiver.
//
// Reset clears the packet state, the kept address and the queue, and loads
// the expected ID with 0x1234.
`timescale 1ns / 1ps

module dns_response_a_record_parser #(
	parameter int OFFSET_BITS = dnsap_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] address,
	output logic [3:0]  response_code,
	output logic        wait_cleared
);
	import dnsap_pkg::*;

	logic [15:0] expected_id_q;
	logic        take;
	logic        res_push;
	result_t     res;
	result_t     res_out;

	// Configuration register, written without handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q <= ID_RESET;
		end else if (cfg_wr_en) begin
			expected_id_q <= cfg_wr_data;
		end
	end

	// A byte transfer needs a free queue entry, since any byte may end a packet.
	assign take = in_valid && in_ready;

	dnsap_parse #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.expected_id (expected_id_q),
		.res_push    (res_push),
		.res         (res)
	);

	dnsap_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.has_room  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (res_out)
	);

	assign status        = res_out.status;
	assign address       = res_out.address;
	assign response_code = res_out.response_code;
	assign wait_cleared  = res_out.wait_cleared;

`include "dns_response_a_record_parser_assert.svh"

	`DNSAP_ASSERT_SAME(a_push_on_last, res_push, take && last_byte, "result without final byte")
	`DNSAP_ASSERT_NEXT(a_push_shows, res_push, out_valid, "pushed result not presented")
	`DNSAP_ASSERT_SAME(a_found_clears, out_valid && status == ST_FOUND, wait_cleared, "found must clear wait")
	`DNSAP_ASSERT_SAME(a_addr_zero, out_valid && status != ST_FOUND, address == 32'd0, "address outside found")
	`DNSAP_ASSERT_SAME(a_short_rcode, out_valid && status == ST_SHORT, response_code == 4'd0, "rcode on short packet")

endmodule

[rtl/dnsap_parse.sv]
// Byte-wise packet parser: holds the packet state and produces the outcome
// on the final byte of each packet. Depends on dnsap_pkg.
`timescale 1ns / 1ps

module dnsap_parse #(
	parameter int OFFSET_BITS = dnsap_pkg::OFFSET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [15:0]         expected_id,
	output logic                res_push,
	output dnsap_pkg::result_t  res
);
	import dnsap_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

	logic [OFFSET_BITS-1:0] offset_q, offset_n;
	phase_t                 phase_q, phase_n;
	logic [15:0]            skip_q, skip_n;
	logic [15:0]            section_q, section_n;
	logic [FIELD_IDX_W-1:0] idx_q, idx_n;
	logic [2:0]             verdict_q, verdict_n;
	logic                   found_flag_q, found_flag_n;
	logic [31:0]            found_addr_q, found_addr_n;

	logic [7:0]  hdr_q [HDR_LEN];
	logic [7:0]  type_hi_q, type_lo_q, rdlen_hi_q;
	logic [23:0] addr_lo_q;

	logic                 hdr_we;
	logic [HDR_IDX_W-1:0] hdr_idx;
	logic                 type_hi_we, type_lo_we, rdlen_hi_we;
	logic                 addr_we;
	logic [7:0]           type_hi_d;

	logic        ptr;
	logic        q_done;
	logic [15:0] sec_dec;
	logic [15:0] an_word, qd_word, id_word, flags_word, type_word, rdlen_word;
	logic [2:0]  status_d;

	assign ptr        = (data_byte & PTR_MASK) == PTR_MASK;
	assign id_word    = {hdr_q[0], hdr_q[1]};
	assign flags_word = {hdr_q[2], hdr_q[3]};
	assign qd_word    = {hdr_q[4], hdr_q[5]};
	assign an_word    = {hdr_q[6], hdr_q[7]};
	assign type_word  = {type_hi_q, type_lo_q};
	assign rdlen_word = {rdlen_hi_q, data_byte};
	assign sec_dec    = section_q - 16'd1;

	always_comb begin
		offset_n     = offset_q;
		phase_n      = phase_q;
		skip_n       = skip_q;
		section_n    = section_q;
		idx_n        = idx_q;
		verdict_n    = verdict_q;
		found_flag_n = found_flag_q;
		found_addr_n = found_addr_q;
		hdr_we       = 1'b0;
		hdr_idx      = offset_q[HDR_IDX_W-1:0];
		type_hi_we   = 1'b0;
		type_hi_d    = data_byte;
		type_lo_we   = 1'b0;
		rdlen_hi_we  = 1'b0;
		addr_we      = 1'b0;
		q_done       = 1'b0;
		status_d     = ST_SHORT;
		res_push     = 1'b0;
		res          = '0;

		if (take && offset_q != OFF_MAX) begin
			offset_n = offset_q + OFFSET_BITS'(1);
			if (skip_q != 16'd0) begin
				skip_n = skip_q - 16'd1;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						hdr_we = offset_q < OFFSET_BITS'(HDR_LEN);
						if (offset_q == OFFSET_BITS'(HDR_LEN - 1)) begin
							priority if (id_word != expected_id) begin
								verdict_n = ST_WRONG_ID;
							end else if ((flags_word & RCODE_MASK) != 16'd0) begin
								verdict_n = ST_SRV_ERROR;
							end else if ((flags_word & QR_MASK) == 16'd0) begin
								verdict_n = ST_NOT_RESP;
							end else if (an_word == 16'd0) begin
								verdict_n = ST_NO_ANSWER;
							end else begin
								verdict_n = VERDICT_OK;
							end
							if (verdict_n != VERDICT_OK) begin
								phase_n = PH_HDR_FAIL;
							end else if (qd_word != 16'd0) begin
								section_n = qd_word;
								phase_n   = PH_Q_LABEL;
							end else begin
								section_n = an_word;
								phase_n   = PH_A_ENTRY;
							end
						end
					end
					PH_Q_LABEL: begin
						if (data_byte == 8'd0) begin
							skip_n = 16'd4;
							q_done = 1'b1;
						end else if (ptr) begin
							skip_n  = 16'd1;
							phase_n = PH_Q_AFTER;
						end else begin
							skip_n = {8'd0, data_byte};
						end
					end
					PH_Q_AFTER: begin
						skip_n = (data_byte == 8'd0) ? 16'd4 : 16'd3;
						q_done = 1'b1;
					end
					PH_A_ENTRY, PH_A_START: begin
						if (ptr) begin
							skip_n  = 16'd1;
							phase_n = PH_A_FIELDS;
							idx_n   = '0;
						end else if (data_byte == 8'd0) begin
							phase_n = PH_A_FIELDS;
							idx_n   = '0;
						end else begin
							skip_n  = {8'd0, data_byte};
							phase_n = PH_A_LABEL;
						end
					end
					PH_A_LABEL: begin
						if (data_byte == 8'd0) begin
							phase_n = PH_A_FIELDS;
							idx_n   = '0;
						end else if (ptr) begin
							skip_n  = 16'd1;
							phase_n = PH_A_AFTER;
						end else begin
							skip_n = {8'd0, data_byte};
						end
					end
					PH_A_AFTER: begin
						phase_n = PH_A_FIELDS;
						idx_n   = '0;
						if (data_byte != 8'd0) begin
							type_hi_we = 1'b1;
							idx_n      = FIELD_IDX_W'(1);
						end
					end
					PH_A_FIELDS: begin
						type_hi_we  = idx_q == FIELD_IDX_W'(0);
						type_lo_we  = idx_q == FIELD_IDX_W'(1);
						rdlen_hi_we = idx_q == FIELD_IDX_W'(FIELD_LEN - 2);
						idx_n       = idx_q + FIELD_IDX_W'(1);
						if (idx_q == FIELD_IDX_W'(FIELD_LEN - 1)) begin
							if (type_word == TYPE_A && rdlen_word == 16'(RDATA_LEN)) begin
								phase_n = PH_A_RDATA;
								idx_n   = '0;
							end else begin
								skip_n    = rdlen_word;
								section_n = sec_dec;
								phase_n   = (sec_dec == 16'd0) ? PH_DONE : PH_A_START;
							end
						end
					end
					PH_A_RDATA: begin
						addr_we = 1'b1;
						idx_n   = idx_q + FIELD_IDX_W'(1);
						if (idx_q == FIELD_IDX_W'(RDATA_LEN - 1)) begin
							found_addr_n = {data_byte, addr_lo_q};
							found_flag_n = 1'b1;
							phase_n      = PH_DONE;
						end
					end
					default: begin
					end
				endcase
				if (q_done) begin
					if (sec_dec == 16'd0) begin
						section_n = an_word;
						phase_n   = PH_A_ENTRY;
					end else begin
						section_n = sec_dec;
						phase_n   = PH_Q_LABEL;
					end
				end
			end
		end

		if (take && last_byte) begin
			priority if (phase_n == PH_HEADER) begin
				status_d = ST_SHORT;
			end else if (phase_n == PH_HDR_FAIL) begin
				status_d = verdict_n;
			end else if (phase_n == PH_Q_LABEL || phase_n == PH_Q_AFTER ||
					phase_n == PH_A_ENTRY) begin
				status_d = ST_MALFORMED;
			end else if (found_flag_n) begin
				status_d = ST_FOUND;
			end else begin
				status_d = ST_NONE;
			end
			res_push          = 1'b1;
			res.status        = status_d;
			res.address       = (status_d == ST_FOUND) ? found_addr_n : 32'd0;
			res.response_code = (status_d == ST_SHORT) ? 4'd0 : hdr_q[3][3:0];
			res.wait_cleared  = status_d == ST_SRV_ERROR || status_d == ST_NO_ANSWER ||
				status_d == ST_MALFORMED || status_d == ST_FOUND ||
				(status_d == ST_NONE && found_addr_n == 32'd0);

			// The packet is finished: everything but the kept address starts over.
			offset_n     = '0;
			phase_n      = PH_HEADER;
			skip_n       = '0;
			section_n    = '0;
			idx_n        = '0;
			verdict_n    = VERDICT_OK;
			found_flag_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= '0;
			phase_q      <= PH_HEADER;
			skip_q       <= '0;
			section_q    <= '0;
			idx_q        <= '0;
			verdict_q    <= VERDICT_OK;
			found_flag_q <= 1'b0;
			found_addr_q <= '0;
		end else begin
			offset_q     <= offset_n;
			phase_q      <= phase_n;
			skip_q       <= skip_n;
			section_q    <= section_n;
			idx_q        <= idx_n;
			verdict_q    <= verdict_n;
			found_flag_q <= found_flag_n;
			found_addr_q <= found_addr_n;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_q[hdr_idx] <= data_byte;
		end
		if (type_hi_we) begin
			type_hi_q <= type_hi_d;
		end
		if (type_lo_we) begin
			type_lo_q <= data_byte;
		end
		if (rdlen_hi_we) begin
			rdlen_hi_q <= data_byte;
		end
		if (addr_we) begin
			unique case (idx_q[1:0])
				2'd0: addr_lo_q[7:0]   <= data_byte;
				2'd1: addr_lo_q[15:8]  <= data_byte;
				2'd2: addr_lo_q[23:16] <= data_byte;
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/dnsap_outq.sv]
// Two-entry result queue between the parser and the result channel.
// Depends on dnsap_pkg.
`timescale 1ns / 1ps

module dnsap_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dnsap_pkg::result_t push_data,
	output logic               has_room,
	output logic               out_valid,
	input  logic               out_ready,
	output dnsap_pkg::result_t out_data
);
	import dnsap_pkg::*;

	result_t    mem [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = count_q != 2'd0;
	assign has_room  = count_q != 2'd2;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

[bench/dns_response_a_record_parser_tb.sv]
// Self-checking testbench for dns_response_a_record_parser: random and directed DNS responses
// go in byte by byte, and each packet outcome is checked against a built-in parser model.
// Depends on dnsap_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

module dns_response_a_record_parser_tb;
	import dnsap_pkg::*;

	// The byte offset stops counting here. Bytes that arrive after that point are dropped,
	// but the last-byte flag still closes the packet.
	localparam int OFFSET_LIMIT = (1 << OFFSET_BITS_DEF) - 1;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE_CYCLES = 8;

	// Record types and class that the packet builder uses.
	localparam logic [15:0] RR_CNAME    = 16'd5;
	localparam logic [15:0] RR_AAAA     = 16'd28;
	localparam logic [15:0] RR_CLASS_IN = 16'd1;

	// Answer shapes for the packet builder.
	localparam int ANS_A      = 0;
	localparam int ANS_CNAME  = 1;
	localparam int ANS_AAAA   = 2;
	localparam int ANS_A_WIDE = 3;
	localparam int ANS_OTHER  = 4;

	// Ways a domain name can be encoded.
	localparam int NAME_LABELS = 0;
	localparam int NAME_PTR    = 1;
	localparam int NAME_MIXED  = 2;

	typedef struct {
		logic [7:0] data;
		logic       last;
		int         gap;
		bit         drain;
	} byte_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = 16'h0000;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [31:0] address;
	logic [3:0]  response_code;
	logic        wait_cleared;

	dns_response_a_record_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.address(address),
		.response_code(response_code),
		.wait_cleared(wait_cleared)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Bytes waiting to be sent, the packet being built, and the outcomes still owed by the
	// block, oldest first.
	byte_item_t byte_q[$];
	logic [7:0] pkt[$];
	result_t    outcome_q[$];

	int mismatch_count = 0;
	int bytes_queued = 0;
	int packets_queued = 0;
	bit idle_on = 1'b1;

	// Transfers seen at the last rising edge; the falling-edge processes use them.
	logic byte_taken = 1'b0;
	logic result_taken = 1'b0;

	// Long receiver hold-off: requested by the stimulus, served once by the receiver.
	bit hold_request = 1'b0;
	bit hold_served = 1'b0;
	int hold_left = 0;

	// Parser model state. The expected ID is our copy of the block's register.
	logic [15:0] id_setting = ID_RESET;
	int          walk_offset = 0;
	logic [7:0]  hdr_bytes[HDR_LEN];
	phase_t      walk_phase = PH_HEADER;
	int          skip_left = 0;
	logic [15:0] count_left = 16'd0;
	logic [7:0]  rec_bytes[FIELD_LEN];
	logic [31:0] kept_address = 32'd0;
	bit          addr_found = 1'b0;
	int          field_pos = 0;
	logic [2:0]  hdr_verdict = VERDICT_OK;

	// One question is finished. After the last one, the answer walk begins with the answer
	// count from the header.
	task automatic close_question();
		count_left = count_left - 16'd1;
		if (count_left == 16'd0) begin
			count_left = {hdr_bytes[6], hdr_bytes[7]};
			walk_phase = PH_A_ENTRY;
		end else begin
			walk_phase = PH_Q_LABEL;
		end
	endtask

	// Advances the parser model by one accepted byte. On the last byte of a packet it
	// appends the expected outcome and clears the per-packet state; the found address
	// is kept across packets.
	task automatic predict_outcome(input logic [7:0] b, input logic last);
		logic [15:0] flags;
		bit          is_ptr;
		result_t     r;
		is_ptr = (b & PTR_MASK) == PTR_MASK;
		if (walk_offset < OFFSET_LIMIT) begin
			if (skip_left > 0) begin
				skip_left--;
			end else begin
				case (walk_phase)
					PH_HEADER: begin
						if (walk_offset < HDR_LEN)
							hdr_bytes[walk_offset] = b;
						if (walk_offset == HDR_LEN - 1) begin
							flags = {hdr_bytes[2], hdr_bytes[3]};
							if ({hdr_bytes[0], hdr_bytes[1]} != id_setting)
								hdr_verdict = ST_WRONG_ID;
							else if ((flags & RCODE_MASK) != 16'd0)
								hdr_verdict = ST_SRV_ERROR;
							else if ((flags & QR_MASK) == 16'd0)
								hdr_verdict = ST_NOT_RESP;
							else if ({hdr_bytes[6], hdr_bytes[7]} == 16'd0)
								hdr_verdict = ST_NO_ANSWER;
							else
								hdr_verdict = VERDICT_OK;
							if (hdr_verdict != VERDICT_OK) begin
								walk_phase = PH_HDR_FAIL;
							end else if ({hdr_bytes[4], hdr_bytes[5]} != 16'd0) begin
								count_left = {hdr_bytes[4], hdr_bytes[5]};
								walk_phase = PH_Q_LABEL;
							end else begin
								count_left = {hdr_bytes[6], hdr_bytes[7]};
								walk_phase = PH_A_ENTRY;
							end
						end
					end
					PH_Q_LABEL: begin
						// A zero ends the name; the type and class follow.
						if (b == 8'd0) begin
							skip_left = 4;
							close_question();
						end else if (is_ptr) begin
							skip_left = 1;
							walk_phase = PH_Q_AFTER;
						end else begin
							skip_left = b;
						end
					end
					PH_Q_AFTER: begin
						// The byte after a pointer's offset decides how much more is passed over.
						skip_left = (b == 8'd0) ? 4 : 3;
						close_question();
					end
					PH_A_ENTRY, PH_A_START: begin
						if (is_ptr) begin
							skip_left = 1;
							walk_phase = PH_A_FIELDS;
							field_pos = 0;
						end else if (b == 8'd0) begin
							walk_phase = PH_A_FIELDS;
							field_pos = 0;
						end else begin
							skip_left = b;
							walk_phase = PH_A_LABEL;
						end
					end
					PH_A_LABEL: begin
						if (b == 8'd0) begin
							walk_phase = PH_A_FIELDS;
							field_pos = 0;
						end else if (is_ptr) begin
							skip_left = 1;
							walk_phase = PH_A_AFTER;
						end else begin
							skip_left = b;
						end
					end
					PH_A_AFTER: begin
						// A nonzero byte here is already the first byte of the fixed fields.
						walk_phase = PH_A_FIELDS;
						field_pos = 0;
						if (b != 8'd0) begin
							rec_bytes[0] = b;
							field_pos = 1;
						end
					end
					PH_A_FIELDS: begin
						if (field_pos < FIELD_LEN)
							rec_bytes[field_pos] = b;
						field_pos++;
						if (field_pos >= FIELD_LEN) begin
							if ({rec_bytes[0], rec_bytes[1]} == TYPE_A &&
									{rec_bytes[8], rec_bytes[9]} == 16'(RDATA_LEN)) begin
								walk_phase = PH_A_RDATA;
								field_pos = 0;
							end else begin
								skip_left = {rec_bytes[8], rec_bytes[9]};
								count_left = count_left - 16'd1;
								walk_phase = (count_left == 16'd0) ? PH_DONE : PH_A_START;
							end
						end
					end
					PH_A_RDATA: begin
						if (field_pos < RDATA_LEN)
							rec_bytes[field_pos] = b;
						field_pos++;
						if (field_pos >= RDATA_LEN) begin
							kept_address = {rec_bytes[3], rec_bytes[2], rec_bytes[1], rec_bytes[0]};
							addr_found = 1'b1;
							walk_phase = PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
			walk_offset++;
		end

		if (last) begin
			r = '0;
			if (walk_phase == PH_HEADER) begin
				r.status = ST_SHORT;
			end else begin
				r.response_code = hdr_bytes[3][3:0];
				if (walk_phase == PH_HDR_FAIL)
					r.status = hdr_verdict;
				else if (walk_phase == PH_Q_LABEL || walk_phase == PH_Q_AFTER ||
						walk_phase == PH_A_ENTRY)
					r.status = ST_MALFORMED;
				else if (addr_found)
					r.status = ST_FOUND;
				else
					r.status = ST_NONE;
			end
			r.wait_cleared = (r.status == ST_SRV_ERROR || r.status == ST_NO_ANSWER ||
				r.status == ST_MALFORMED || r.status == ST_FOUND ||
				(r.status == ST_NONE && kept_address == 32'd0));
			if (r.status == ST_FOUND)
				r.address = kept_address;
			outcome_q.push_back(r);
			walk_offset = 0;
			walk_phase = PH_HEADER;
			skip_left = 0;
			count_left = 16'd0;
			field_pos = 0;
			addr_found = 1'b0;
			hdr_verdict = VERDICT_OK;
		end
	endtask

	// Monitor: samples both channels at the rising edge. Accepted bytes feed the model,
	// and each accepted outcome is compared with the oldest one the model owes.
	always @(posedge clk) begin : monitor_blk
		result_t want;
		byte_taken <= in_valid && in_ready;
		result_taken <= out_valid && out_ready;
		if (arst_n && in_valid && in_ready)
			predict_outcome(data_byte, last_byte);
		if (arst_n && out_valid && out_ready) begin
			if (outcome_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: outcome with none owed: status %0d address %h rcode %0d cleared %0b",
						$realtime, status, address, response_code, wait_cleared);
			end else begin
				want = outcome_q.pop_front();
				if (status !== want.status || address !== want.address ||
						response_code !== want.response_code ||
						wait_cleared !== want.wait_cleared) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: outcome mismatch: expected status %0d address %h rcode %0d ",
							"cleared %0b, got status %0d address %h rcode %0d cleared %0b"},
							$realtime, want.status, want.address, want.response_code,
							want.wait_cleared, status, address, response_code, wait_cleared);
				end
			end
		end
	end

	// Driver: at the falling edge, once the previous byte has been transferred, it waits out
	// the next byte's gap (and, for a packet marked to drain, until every outcome is in),
	// then offers that byte and holds it until the transfer.
	int tx_wait = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || byte_taken) begin
			if (byte_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (tx_wait < byte_q[0].gap) begin
				tx_wait++;
				in_valid <= 1'b0;
			end else if (byte_q[0].drain && outcome_q.size() != 0) begin
				in_valid <= 1'b0;
			end else begin
				tx_wait = 0;
				data_byte <= byte_q[0].data;
				last_byte <= byte_q[0].last;
				in_valid <= 1'b1;
				void'(byte_q.pop_front());
			end
		end
	end

	// Receiver: while idling is on, it waits a random gap before each outcome. When asked, it holds
	// off for a long stretch so that the result queue fills and the input stalls.
	int rx_wait = 0;
	int rx_gap = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_request && !hold_served) begin
			hold_served = 1'b1;
			hold_left = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else if (out_ready && !result_taken) begin
			// Ready is up and no transfer has happened yet; keep it up.
		end else if (rx_wait < rx_gap) begin
			rx_wait++;
			out_ready <= 1'b0;
		end else begin
			rx_wait = 0;
			rx_gap = idle_on ? $urandom_range(0, 7) : 0;
			out_ready <= 1'b1;
		end
	end

	// Watchdog on the total run length.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	task automatic push_byte(input logic [7:0] v);
		pkt.push_back(v);
	endtask

	task automatic push_word(input logic [15:0] w);
		pkt.push_back(w[15:8]);
		pkt.push_back(w[7:0]);
	endtask

	// Header: ID, flags, question and answer counts; the authority and additional counts
	// are random, since the parser never looks at them.
	task automatic push_header(input logic [15:0] id, input logic [15:0] flags,
			input logic [15:0] qd, input logic [15:0] an);
		push_word(id);
		push_word(flags);
		push_word(qd);
		push_word(an);
		push_word(16'($urandom));
		push_word(16'($urandom));
	endtask

	task automatic push_name(input int form);
		int labels;
		int len;
		labels = (form == NAME_LABELS) ? $urandom_range(0, 3) :
			(form == NAME_MIXED) ? $urandom_range(1, 3) : 0;
		repeat (labels) begin
			len = $urandom_range(1, 12);
			push_byte(8'(len));
			repeat (len) push_byte(8'($urandom));
		end
		if (form == NAME_LABELS) begin
			push_byte(8'd0);
		end else begin
			push_byte(PTR_MASK | 8'($urandom_range(0, 63)));
			push_byte(8'($urandom));
		end
	endtask

	task automatic push_question();
		push_name($urandom_range(0, 2));
		push_word($urandom_range(0, 1) ? TYPE_A : 16'($urandom));
		push_word(RR_CLASS_IN);
	endtask

	task automatic push_answer(input int kind, input int form);
		logic [15:0] rtype;
		logic [15:0] rlen;
		push_name(form);
		case (kind)
			ANS_A: begin
				rtype = TYPE_A;
				rlen = 16'(RDATA_LEN);
			end
			ANS_CNAME: begin
				rtype = RR_CNAME;
				rlen = 16'($urandom_range(2, 20));
			end
			ANS_AAAA: begin
				rtype = RR_AAAA;
				rlen = 16'd16;
			end
			ANS_A_WIDE: begin
				// An A record whose data length is 0 to 3 or 5 to 8, never four.
				rtype = TYPE_A;
				rlen = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) :
					16'($urandom_range(5, 8));
			end
			default: begin
				rtype = 16'($urandom);
				rlen = 16'($urandom_range(0, 6));
			end
		endcase
		push_word(rtype);
		push_word(RR_CLASS_IN);
		repeat (4) push_byte(8'($urandom));
		push_word(rlen);
		repeat (rlen) push_byte(8'($urandom));
	endtask

	// Moves the first keep bytes of the packet under construction to the send queue,
	// flagging the final one, and drops the rest.
	task automatic queue_packet(input int keep, input bit drain);
		byte_item_t it;
		for (int i = 0; i < keep; i++) begin
			it.data = pkt[i];
			it.last = (i == keep - 1);
			it.gap = idle_on ? $urandom_range(0, 7) : 0;
			it.drain = drain && (i == 0);
			byte_q.push_back(it);
		end
		pkt.delete();
		bytes_queued += keep;
		packets_queued++;
	endtask

	// A response that is mostly well formed: a few header faults, random questions and
	// answers, some trailing bytes, and now and then a cut at a random point.
	task automatic queue_random_packet();
		int          pick;
		int          qd;
		int          an;
		int          keep;
		logic [15:0] id;
		logic [15:0] flags;
		pick = $urandom_range(0, 99);
		id = id_setting;
		flags = {1'b1, 11'($urandom), 4'h0};
		if (pick < 5)
			id = id ^ (16'd1 << $urandom_range(0, 15));
		else if (pick < 10)
			flags[3:0] = 4'($urandom_range(1, 15));
		else if (pick < 14)
			flags[15] = 1'b0;
		qd = $urandom_range(0, 2);
		an = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
		push_header(id, flags, 16'(qd), 16'(an));
		repeat (qd) push_question();
		repeat (an) push_answer($urandom_range(ANS_A, ANS_OTHER), $urandom_range(0, 2));
		repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
		keep = pkt.size();
		if ($urandom_range(0, 5) == 0)
			keep = $urandom_range(1, pkt.size());
		queue_packet(keep, $urandom_range(0, 19) == 0);
	endtask

	// Mostly well-formed responses, with a quarter of raw noise, some of it behind a
	// header with the expected ID and response flags.
	task automatic queue_random_traffic(input int min_bytes, input int min_packets);
		int start_bytes;
		int start_packets;
		start_bytes = bytes_queued;
		start_packets = packets_queued;
		while (bytes_queued - start_bytes < min_bytes ||
				packets_queued - start_packets < min_packets) begin
			if ($urandom_range(0, 3) != 0) begin
				queue_random_packet();
			end else begin
				if ($urandom_range(0, 1))
					push_header(id_setting, 16'h8180, 16'($urandom_range(0, 3)),
						16'($urandom_range(0, 3)));
				repeat ($urandom_range(1, 40)) push_byte(8'($urandom));
				queue_packet(pkt.size(), 1'b0);
			end
		end
	endtask

	// Blocks until every byte is sent and every owed outcome has arrived, then lets the block settle.
	task automatic wait_all_settled();
		while (byte_q.size() != 0 || in_valid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The expected ID is only rewritten while the block is idle.
	task automatic write_expected_id(input logic [15:0] v);
		wait_all_settled();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		id_setting = v;
	endtask

	initial begin : stimulus
		logic [15:0] id;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed responses under the reset value of the expected ID.
		id = id_setting;
		// A lone byte, then a header one byte short: both too short.
		push_byte(8'hFF);
		queue_packet(1, 1'b0);
		push_header(id, 16'h8180, 16'd1, 16'd1);
		queue_packet(HDR_LEN - 1, 1'b0);
		// No A record while the kept address is still zero.
		push_header(id, 16'h8180, 16'd0, 16'd1);
		push_answer(ANS_CNAME, NAME_PTR);
		queue_packet(pkt.size(), 1'b0);
		// A record found after one question, with trailing bytes that are ignored.
		push_header(id, 16'h8180, 16'd1, 16'd1);
		push_question();
		push_answer(ANS_A, NAME_PTR);
		push_byte(8'h00);
		push_byte(8'hFF);
		queue_packet(pkt.size(), 1'b0);
		// No A record once an address is kept.
		push_header(id, 16'h8180, 16'd0, 16'd1);
		push_answer(ANS_AAAA, NAME_LABELS);
		queue_packet(pkt.size(), 1'b0);
		// Each header check fails once: ID, rcode, response bit, answer count.
		push_header(id ^ 16'h8000, 16'h8180, 16'd1, 16'd1);
		queue_packet(pkt.size(), 1'b0);
		push_header(id, 16'h818F, 16'd0, 16'd1);
		queue_packet(pkt.size(), 1'b0);
		push_header(id, 16'h0100, 16'd0, 16'd1);
		queue_packet(pkt.size(), 1'b0);
		push_header(id, 16'h8180, 16'd1, 16'd0);
		push_question();
		queue_packet(pkt.size(), 1'b0);
		// Ends inside the questions, and right after the header: both malformed.
		push_header(id, 16'h8180, 16'd2, 16'd1);
		push_byte(8'd5);
		repeat (3) push_byte(8'($urandom));
		queue_packet(pkt.size(), 1'b0);
		push_header(id, 16'h8180, 16'd0, 16'd2);
		queue_packet(pkt.size(), 1'b0);
		// A question that is only a pointer; sent after every outcome is in.
		push_header(id, 16'h8180, 16'd1, 16'd2);
		push_byte(8'hC0);
		push_byte(8'h0C);
		push_word(TYPE_A);
		push_word(RR_CLASS_IN);
		push_answer(ANS_A, NAME_MIXED);
		push_answer(ANS_CNAME, NAME_PTR);
		queue_packet(pkt.size(), 1'b1);
		// Largest counts, cut short.
		push_header(id, 16'hFFF0, 16'hFFFF, 16'hFFFF);
		push_question();
		queue_packet(pkt.size(), 1'b0);
		// Ends inside the second answer: the walk stops with no record.
		push_header(id, 16'h8180, 16'd0, 16'd2);
		push_answer(ANS_A_WIDE, NAME_LABELS);
		push_answer(ANS_A, NAME_PTR);
		queue_packet(pkt.size() - 2, 1'b0);
		// Answer name of labels that ends in a pointer.
		push_header(id, 16'h8180, 16'd0, 16'd1);
		push_answer(ANS_A, NAME_MIXED);
		queue_packet(pkt.size(), 1'b0);

		write_expected_id(16'h0000);
		queue_random_traffic(150, 3);

		// No idling, and a long receiver hold-off while short packets keep coming.
		write_expected_id(16'hFFFF);
		idle_on = 1'b0;
		hold_request = 1'b1;
		repeat (12) begin
			push_header(id_setting, 16'($urandom), 16'($urandom), 16'($urandom));
			queue_packet(pkt.size(), 1'b0);
		end
		queue_random_traffic(100, 2);

		write_expected_id(16'($urandom));
		idle_on = 1'b1;
		queue_random_traffic(150, 3);

		write_expected_id(ID_RESET);
		idle_on = 1'b1;
		queue_random_traffic(100, 2);

		wait_all_settled();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/dnsap_pkg.sv
rtl/dnsap_parse.sv
rtl/dnsap_outq.sv
rtl/dns_response_a_record_parser.sv
bench/dns_response_a_record_parser_tb.sv
